/* design/ttc_pkg.sv */
// shared types, constants and coefficient tables of the thermistor converter
`timescale 1ns / 1ps

package ttc_pkg;

  localparam int unsigned SAMPLES_PER_AVERAGE = 10;
  localparam int unsigned NUM_BANDS = 13;

  // ceil(2^24 / samples per average), exact floor quotient for any 18-bit sum
  localparam logic [31:0] AVG_RECIP =
    32'((33'd16777216 + 33'(SAMPLES_PER_AVERAGE) - 33'd1) / 33'(SAMPLES_PER_AVERAGE));

  localparam logic [11:0] ADC_FULL = 12'd4095;
  localparam logic [3:0]  NO_BAND  = 4'd15;
  localparam logic [3:0]  TOP_BAND = 4'd12;
  localparam logic [33:0] TOP_EDGE = 34'd5975552;
  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam logic [48:0] ONE_Q48  = 49'h1_0000_0000_0000;
  localparam logic [19:0] RREF_RESET = 20'd9870;

  localparam logic signed [9:0] T_ZERO_KELVIN = -10'sd273;
  localparam logic signed [9:0] T_MAX = 10'sd511;
  localparam logic signed [9:0] T_MIN = -10'sd512;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_HELD    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } alu_op_t;

  // request to the shared arithmetic unit
  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [48:0] opa;
    logic [48:0] opb;
  } alu_cmd_t;

  // answer of the shared arithmetic unit
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [71:0] result;
  } alu_rsp_t;

  // round(man * 2^48 / 10^k) by long division, elaboration only
  function automatic logic [39:0] coef_scale(input logic [39:0] man, input int unsigned k);
    logic [95:0] num;
    logic [59:0] den;
    logic [59:0] rem;
    logic [95:0] quo;
    den = 60'd1;
    for (int unsigned i = 0; i < k; i++) den = den * 60'd10;
    num = {8'd0, man, 48'd0};
    rem = '0;
    quo = '0;
    for (int i = 95; i >= 0; i--) begin
      rem = {rem[58:0], num[i]};
      quo = {quo[94:0], 1'b0};
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    if ({rem, 1'b0} >= {1'b0, den}) quo = quo + 96'd1;
    return quo[39:0];
  endfunction

  localparam logic [33:0] BAND_LOW [NUM_BANDS] = '{
    34'd6544, 34'd9378, 34'd13650, 34'd20224, 34'd30567, 34'd47284, 34'd75188,
    34'd123572, 34'd211610, 34'd381696, 34'd730624, 34'd1498880, 34'd3332608
  };

  localparam logic [39:0] COEF_A [NUM_BANDS] = '{
    coef_scale(40'd1673744484, 12), coef_scale(40'd1626967742, 12),
    coef_scale(40'd1640897658, 12), coef_scale(40'd1622693990, 12),
    coef_scale(40'd1556142469, 12), coef_scale(40'd1584648860, 12),
    coef_scale(40'd1494842800, 12), coef_scale(40'd1462092077, 12),
    coef_scale(40'd1410553889, 12), coef_scale(40'd1373696154, 12),
    coef_scale(40'd1356809063, 12), coef_scale(40'd1393819878, 12),
    coef_scale(40'd1390630395, 12)
  };

  localparam logic [39:0] COEF_B [NUM_BANDS] = '{
    coef_scale(40'd2003603190, 13), coef_scale(40'd2199439949, 13),
    coef_scale(40'd2141247478, 13), coef_scale(40'd2204903946, 13),
    coef_scale(40'd2412217354, 13), coef_scale(40'd2325539830, 13),
    coef_scale(40'd2565749327, 13), coef_scale(40'd2644119345, 13),
    coef_scale(40'd2765768030, 13), coef_scale(40'd2840852189, 13),
    coef_scale(40'd2868265492, 13), coef_scale(40'd2800689802, 13),
    coef_scale(40'd2805660005, 13)
  };

  localparam logic [39:0] COEF_C [NUM_BANDS] = '{
    coef_scale(40'd1178163989, 15), coef_scale(40'd6665851264, 16),
    coef_scale(40'd8149252608, 16), coef_scale(40'd6993132700, 16),
    coef_scale(40'd4013575752, 16), coef_scale(40'd5209143518, 16),
    coef_scale(40'd2659751121, 16), coef_scale(40'd1999218291, 16),
    coef_scale(40'd9992682963, 17), coef_scale(40'd5343930830, 17),
    coef_scale(40'd4378552036, 17), coef_scale(40'd7702209069, 17),
    coef_scale(40'd7520202377, 17)
  };

endpackage

/* design/ttc_alu.sv */
// shared shift-add multiplier and restoring divider, one step per cycle
`timescale 1ns / 1ps

module ttc_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  ttc_pkg::alu_cmd_t cmd,
  output ttc_pkg::alu_rsp_t rsp
);

  localparam logic [5:0] MUL_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS = 6'd49;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  ttc_pkg::alu_op_t  op_r, op_nxt;
  logic [71:0]       p_r, p_nxt;
  logic [39:0]       mcand_r, mcand_nxt;
  logic [48:0]       quo_r, quo_nxt;
  logic [47:0]       rem_r, rem_nxt;
  logic [47:0]       dvsr_r, dvsr_nxt;

  logic [40:0] add_sum;
  logic [49:0] sub_diff;

  // one 41-bit add for multiply, one 50-bit subtract for divide
  assign add_sum  = {1'b0, p_r[71:32]} + (p_r[0] ? {1'b0, mcand_r} : 41'd0);
  assign sub_diff = {1'b0, rem_r, quo_r[48]} - {2'b00, dvsr_r};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    p_nxt     = p_r;
    mcand_nxt = mcand_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvsr_nxt  = dvsr_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd.op;
      if (cmd.op == ttc_pkg::OP_MUL) begin
        p_nxt     = {40'd0, cmd.opb[31:0]};
        mcand_nxt = cmd.opa[39:0];
        cnt_nxt   = MUL_STEPS;
      end else begin
        quo_nxt  = cmd.opa;
        rem_nxt  = '0;
        dvsr_nxt = cmd.opb[47:0];
        cnt_nxt  = DIV_STEPS;
      end
    end else if (busy_r) begin
      if (op_r == ttc_pkg::OP_MUL) begin
        p_nxt = {add_sum, p_r[31:1]};
      end else if (!sub_diff[49]) begin
        rem_nxt = sub_diff[47:0];
        quo_nxt = {quo_r[47:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[46:0], quo_r[48]};
        quo_nxt = {quo_r[47:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= ttc_pkg::OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    p_r     <= p_nxt;
    mcand_r <= mcand_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dvsr_r  <= dvsr_nxt;
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = (op_r == ttc_pkg::OP_MUL) ? p_r : {23'd0, quo_r};

endmodule

/* design/thermistor_temperature_converter_top.sv */
// thermistor converter top: sample averaging, band select, steinhart-hart sequencer
// a sample that does not complete an average is only added to the sum and gives no result
// the sample that completes an average starts a conversion, its length set by the shared
//   multiply/divide unit, one product or quotient at a time; the 24 squarings for the log dominate
// no sample is taken while a conversion runs; a result waits in an output register
// rst_n is synchronous: sum and count clear, no band held, resistor back to 9870 ohms
`timescale 1ns / 1ps

module thermistor_temperature_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  // sample input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] adc_sample
  // result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] temperature_c
  output logic [7:0]  out_tuser,  // [1:0] status
  // reference resistor register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data    // [19:0] reference_resistor_ohms
);

  // sequencer states, one-hot
  typedef enum logic [16:0] {
    S_IDLE  = 17'd1 << 0,
    S_AVG   = 17'd1 << 1,
    S_NUM   = 17'd1 << 2,
    S_RDIV  = 17'd1 << 3,
    S_RANGE = 17'd1 << 4,
    S_BAND  = 17'd1 << 5,
    S_NORM  = 17'd1 << 6,
    S_SQ    = 17'd1 << 7,
    S_LN    = 17'd1 << 8,
    S_TB    = 17'd1 << 9,
    S_L2    = 17'd1 << 10,
    S_L3    = 17'd1 << 11,
    S_TC    = 17'd1 << 12,
    S_DEN   = 17'd1 << 13,
    S_KDIV  = 17'd1 << 14,
    S_OUT   = 17'd1 << 15,
    S_SPARE = 17'd1 << 16
  } state_t;

  state_t state_r, state_nxt;

  // control state
  logic [17:0] sum_r, sum_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  held_r, held_nxt;
  logic [19:0] rref_r, rref_nxt;
  logic        pend_r, pend_nxt;
  logic        out_valid_r, out_valid_nxt;

  // working registers of one conversion
  logic [17:0] wsum_r, wsum_nxt;
  logic [11:0] avg_r, avg_nxt;
  logic [31:0] num_r, num_nxt;
  logic [33:0] r_r, r_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic [33:0] sh_r, sh_nxt;
  logic [5:0]  e_r, e_nxt;
  logic [30:0] m_r, m_nxt;
  logic [23:0] f_r, f_nxt;
  logic [4:0]  it_r, it_nxt;
  logic        neg_r, neg_nxt;
  logic [29:0] l_r, l_nxt;
  logic [47:0] tb_r, tb_nxt;
  logic [35:0] l2_r, l2_nxt;
  logic [39:0] l3_r, l3_nxt;
  logic [47:0] tc_r, tc_nxt;
  logic        dneg_r, dneg_nxt;
  logic [47:0] dabs_r, dabs_nxt;
  logic [9:0]  temp_r, temp_nxt;
  logic [9:0]  out_temp_r, out_temp_nxt;
  logic [1:0]  out_stat_r, out_stat_nxt;

  ttc_pkg::alu_cmd_t alu_cmd;
  ttc_pkg::alu_rsp_t alu_rsp;

  ttc_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (alu_cmd),
    .rsp   (alu_rsp)
  );

  logic        in_acc;
  logic [17:0] sum_add;
  logic [3:0]  cnt_inc;
  logic        in_range;
  logic [6:0]  exp_s;
  logic [30:0] y_s;
  logic [29:0] y_mag;
  logic [48:0] den_sum;
  logic [49:0] den_s;
  logic [31:0] sq;
  logic [48:0] kq;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign sum_add   = sum_r + {6'd0, in_tdata[11:0]};
  assign cnt_inc   = cnt_r + 4'd1;

  assign in_range = (r_r >= ttc_pkg::BAND_LOW[0]) && (r_r <= ttc_pkg::TOP_EDGE);

  // log2 in q.24: exponent is msb position minus 8, fraction from squarings
  assign exp_s = {1'b0, e_r} - 7'd8;
  assign y_s   = {exp_s, f_r};
  assign y_mag = y_s[30] ? 30'(-y_s) : y_s[29:0];

  // denominator a + s*(tb + tc)
  assign den_sum = {1'b0, tb_r} + {1'b0, tc_r};
  assign den_s   = neg_r ? ({10'd0, ttc_pkg::COEF_A[held_r]} - {1'b0, den_sum})
                         : ({10'd0, ttc_pkg::COEF_A[held_r]} + {1'b0, den_sum});

  assign sq = alu_rsp.result[61:30];
  assign kq = alu_rsp.result[48:0];

  // operand selection for the shared unit
  always_comb begin
    alu_cmd.start = pend_r;
    alu_cmd.op    = ttc_pkg::OP_MUL;
    alu_cmd.opa   = '0;
    alu_cmd.opb   = '0;
    case (state_r)
      S_AVG: begin
        // mean by reciprocal multiply, quotient in bits 24 and up
        alu_cmd.opa = {31'd0, wsum_r};
        alu_cmd.opb = {17'd0, ttc_pkg::AVG_RECIP};
      end
      S_NUM: begin
        alu_cmd.opa = {29'd0, rref_r};
        alu_cmd.opb = {37'd0, ttc_pkg::ADC_FULL - avg_r};
      end
      S_RDIV: begin
        alu_cmd.op  = ttc_pkg::OP_DIV;
        alu_cmd.opa = {9'd0, num_r, 8'd0};
        alu_cmd.opb = {37'd0, avg_r};
      end
      S_SQ: begin
        alu_cmd.opa = {18'd0, m_r};
        alu_cmd.opb = {18'd0, m_r};
      end
      S_LN: begin
        alu_cmd.opa = {19'd0, y_mag};
        alu_cmd.opb = {17'd0, ttc_pkg::LN2_Q32};
      end
      S_TB: begin
        alu_cmd.opa = {9'd0, ttc_pkg::COEF_B[held_r]};
        alu_cmd.opb = {19'd0, l_r};
      end
      S_L2: begin
        alu_cmd.opa = {19'd0, l_r};
        alu_cmd.opb = {19'd0, l_r};
      end
      S_L3: begin
        alu_cmd.opa = {13'd0, l2_r};
        alu_cmd.opb = {19'd0, l_r};
      end
      S_TC: begin
        alu_cmd.opa = {9'd0, l3_r};
        alu_cmd.opb = {17'd0, ttc_pkg::COEF_C[held_r][31:0]};
      end
      S_KDIV: begin
        alu_cmd.op  = ttc_pkg::OP_DIV;
        alu_cmd.opa = ttc_pkg::ONE_Q48;
        alu_cmd.opb = {1'b0, dabs_r};
      end
      default: begin
        alu_cmd.op = ttc_pkg::OP_MUL;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    held_nxt      = held_r;
    rref_nxt      = rref_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r;
    wsum_nxt      = wsum_r;
    avg_nxt       = avg_r;
    num_nxt       = num_r;
    r_nxt         = r_r;
    k_nxt         = k_r;
    stat_nxt      = stat_r;
    sh_nxt        = sh_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    f_nxt         = f_r;
    it_nxt        = it_r;
    neg_nxt       = neg_r;
    l_nxt         = l_r;
    tb_nxt        = tb_r;
    l2_nxt        = l2_r;
    l3_nxt        = l3_r;
    tc_nxt        = tc_r;
    dneg_nxt      = dneg_r;
    dabs_nxt      = dabs_r;
    temp_nxt      = temp_r;
    out_temp_nxt  = out_temp_r;
    out_stat_nxt  = out_stat_r;

    if (cfg_valid && cfg_ready) rref_nxt = cfg_data[19:0];
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_inc == 4'(ttc_pkg::SAMPLES_PER_AVERAGE)) begin
            wsum_nxt  = sum_add;
            sum_nxt   = '0;
            cnt_nxt   = '0;
            pend_nxt  = 1'b1;
            state_nxt = S_AVG;
          end else begin
            sum_nxt = sum_add;
            cnt_nxt = cnt_inc;
          end
        end
      end
      S_AVG: begin
        if (alu_rsp.done) begin
          avg_nxt = alu_rsp.result[35:24];
          if (alu_rsp.result[35:24] == 12'd0) begin
            stat_nxt  = ttc_pkg::ST_INVALID;
            temp_nxt  = '0;
            state_nxt = S_OUT;
          end else begin
            pend_nxt  = 1'b1;
            state_nxt = S_NUM;
          end
        end
      end
      S_NUM: begin
        if (alu_rsp.done) begin
          num_nxt   = alu_rsp.result[31:0];
          pend_nxt  = 1'b1;
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        if (alu_rsp.done) begin
          // saturate to q26.8
          r_nxt     = (alu_rsp.result[39:34] != 6'd0) ? '1 : alu_rsp.result[33:0];
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        sh_nxt = r_r;
        e_nxt  = 6'd33;
        if (in_range) begin
          k_nxt     = ttc_pkg::TOP_BAND;
          state_nxt = S_BAND;
        end else if (held_r == ttc_pkg::NO_BAND) begin
          stat_nxt  = ttc_pkg::ST_INVALID;
          temp_nxt  = '0;
          state_nxt = S_OUT;
        end else if (r_r == 34'd0) begin
          // zero resistance reads as zero kelvin
          stat_nxt  = ttc_pkg::ST_HELD;
          temp_nxt  = ttc_pkg::T_ZERO_KELVIN;
          state_nxt = S_OUT;
        end else begin
          stat_nxt  = ttc_pkg::ST_HELD;
          state_nxt = S_NORM;
        end
      end
      S_BAND: begin
        // walk down from the top band, one edge per cycle
        if (r_r >= ttc_pkg::BAND_LOW[k_r]) begin
          held_nxt  = k_r;
          stat_nxt  = ttc_pkg::ST_FOUND;
          state_nxt = S_NORM;
        end else begin
          k_nxt = k_r - 4'd1;
        end
      end
      S_NORM: begin
        if (sh_r[33]) begin
          m_nxt     = sh_r[33:3];
          f_nxt     = '0;
          it_nxt    = '0;
          pend_nxt  = 1'b1;
          state_nxt = S_SQ;
        end else begin
          sh_nxt = {sh_r[32:0], 1'b0};
          e_nxt  = e_r - 6'd1;
        end
      end
      S_SQ: begin
        if (alu_rsp.done) begin
          m_nxt    = sq[31] ? sq[31:1] : sq[30:0];
          f_nxt    = {f_r[22:0], sq[31]};
          it_nxt   = it_r + 5'd1;
          pend_nxt = 1'b1;
          if (it_r == 5'd23) state_nxt = S_LN;
        end
      end
      S_LN: begin
        if (alu_rsp.done) begin
          l_nxt     = alu_rsp.result[61:32];
          neg_nxt   = y_s[30];
          pend_nxt  = 1'b1;
          state_nxt = S_TB;
        end
      end
      S_TB: begin
        if (alu_rsp.done) begin
          tb_nxt    = alu_rsp.result[71:24];
          pend_nxt  = 1'b1;
          state_nxt = S_L2;
        end
      end
      S_L2: begin
        if (alu_rsp.done) begin
          l2_nxt    = alu_rsp.result[59:24];
          pend_nxt  = 1'b1;
          state_nxt = S_L3;
        end
      end
      S_L3: begin
        if (alu_rsp.done) begin
          l3_nxt    = alu_rsp.result[63:24];
          pend_nxt  = 1'b1;
          state_nxt = S_TC;
        end
      end
      S_TC: begin
        if (alu_rsp.done) begin
          tc_nxt    = alu_rsp.result[71:24];
          state_nxt = S_DEN;
        end
      end
      S_DEN: begin
        dneg_nxt = den_s[49];
        dabs_nxt = den_s[49] ? 48'(-den_s) : den_s[47:0];
        if (den_s == 50'd0) begin
          temp_nxt  = ttc_pkg::T_MAX;
          state_nxt = S_OUT;
        end else begin
          pend_nxt  = 1'b1;
          state_nxt = S_KDIV;
        end
      end
      S_KDIV: begin
        if (alu_rsp.done) begin
          // kelvin minus 273, saturated to the output range
          if (!dneg_r) begin
            if (kq > 49'd784) temp_nxt = ttc_pkg::T_MAX;
            else temp_nxt = 10'(kq[10:0] - 11'd273);
          end else begin
            if (kq > 49'd239) temp_nxt = ttc_pkg::T_MIN;
            else temp_nxt = 10'(11'd0 - kq[10:0] - 11'd273);
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = temp_r;
          out_stat_nxt  = stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      held_r      <= ttc_pkg::NO_BAND;
      rref_r      <= ttc_pkg::RREF_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      held_r      <= held_nxt;
      rref_r      <= rref_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wsum_r     <= wsum_nxt;
    avg_r      <= avg_nxt;
    num_r      <= num_nxt;
    r_r        <= r_nxt;
    k_r        <= k_nxt;
    stat_r     <= stat_nxt;
    sh_r       <= sh_nxt;
    e_r        <= e_nxt;
    m_r        <= m_nxt;
    f_r        <= f_nxt;
    it_r       <= it_nxt;
    neg_r      <= neg_nxt;
    l_r        <= l_nxt;
    tb_r       <= tb_nxt;
    l2_r       <= l2_nxt;
    l3_r       <= l3_nxt;
    tc_r       <= tc_nxt;
    dneg_r     <= dneg_nxt;
    dabs_r     <= dabs_nxt;
    temp_r     <= temp_nxt;
    out_temp_r <= out_temp_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_temp_r};
  assign out_tuser  = {6'd0, out_stat_r};

  // a request to the shared unit only while it is free
  a_alu_free: assert property (@(posedge clk) disable iff (!rst_n)
    alu_cmd.start |-> !alu_rsp.busy)
    else $error("arithmetic unit started while busy");

  // held band is either a real band or the no-band mark
  a_held_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r <= ttc_pkg::TOP_BAND) || (held_r == ttc_pkg::NO_BAND))
    else $error("held band out of range");

  // an invalid result always carries zero temperature
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_stat_r == ttc_pkg::ST_INVALID) |-> (out_temp_r == 10'd0))
    else $error("invalid result with nonzero temperature");

  // a valid temperature needs a coefficient set
  a_band_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_stat_r != ttc_pkg::ST_INVALID) |-> (held_r != ttc_pkg::NO_BAND))
    else $error("temperature reported with no band held");

  // sample count never reaches the block size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < 4'(ttc_pkg::SAMPLES_PER_AVERAGE))
    else $error("sample count overran");

endmodule

/* tb/tb_thermistor_temperature_converter_top.sv */
// testbench of the thermistor converter: scoreboard against a built-in integer predictor
`timescale 1ns / 1ps

module tb_thermistor_temperature_converter_top;

  localparam int CYCLE_LIMIT = 1500000;
  localparam longint unsigned R_SAT = (64'd1 << 34) - 1;

  typedef struct {
    logic signed [9:0] temp_c;
    ttc_pkg::status_t  status;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [7:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data = '0;

  // predictor state
  logic [19:0] rref_ohms;
  logic [17:0] accum_sum;
  logic [3:0]  accum_count;
  logic [3:0]  held_set;
  reading_t    pending_readings[$];

  int errors = 0;
  int cycles = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;

  // lower band edges in q26.8
  const longint unsigned band_floor[13] = '{
    6544, 9378, 13650, 20224, 30567, 47284, 75188,
    123572, 211610, 381696, 730624, 1498880, 3332608
  };
  // coefficient mantissas: a*1e-12, b*1e-13, c*10^-c_pow
  const longint unsigned a_man[13] = '{
    64'd1673744484, 64'd1626967742, 64'd1640897658, 64'd1622693990, 64'd1556142469,
    64'd1584648860, 64'd1494842800, 64'd1462092077, 64'd1410553889, 64'd1373696154,
    64'd1356809063, 64'd1393819878, 64'd1390630395
  };
  const longint unsigned b_man[13] = '{
    64'd2003603190, 64'd2199439949, 64'd2141247478, 64'd2204903946, 64'd2412217354,
    64'd2325539830, 64'd2565749327, 64'd2644119345, 64'd2765768030, 64'd2840852189,
    64'd2868265492, 64'd2800689802, 64'd2805660005
  };
  const longint unsigned c_man[13] = '{
    64'd1178163989, 64'd6665851264, 64'd8149252608, 64'd6993132700, 64'd4013575752,
    64'd5209143518, 64'd2659751121, 64'd1999218291, 64'd9992682963, 64'd5343930830,
    64'd4378552036, 64'd7702209069, 64'd7520202377
  };
  const int c_pow[13] = '{15, 16, 16, 16, 16, 16, 16, 16, 17, 17, 17, 17, 17};

  thermistor_temperature_converter_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side backpressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= out_idle_pct);

  // round(m * 2^48 / 10^k), half up
  function automatic longint unsigned q48_coef(longint unsigned m, int k);
    logic [127:0] d;
    d = 1;
    for (int i = 0; i < k; i++) d = d * 10;
    return 64'((({64'd0, m} << 48) + (d >> 1)) / d);
  endfunction

  // floor(a*b / 2^24)
  function automatic longint unsigned q24_mul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> 24);
  endfunction

  // |ln(r)| in q.24 for q26.8 resistance, sign returned separately
  function automatic longint unsigned ln_mag(longint unsigned r, output bit neg);
    int unsigned e;
    longint unsigned t, m, f, mag;
    longint y;
    e = 0;
    t = r;
    f = 0;
    while (t > 1) begin
      t = t >> 1;
      e++;
    end
    m = (e <= 30) ? (r << (30 - e)) : (r >> (e - 30));
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f = f | 1;
      end
    end
    y = (longint'(e) - 8) * 16777216 + longint'(f);
    neg = (y < 0);
    mag = (y < 0) ? longint'(-y) : longint'(y);
    return (mag * longint'(ttc_pkg::LN2_Q32)) >> 32;
  endfunction

  // steinhart-hart in celsius before saturation
  function automatic longint steinhart_celsius(longint unsigned r, int set);
    longint unsigned l, tb, tc, l3;
    longint den, kelvin;
    bit neg;
    if (r == 0) return -273;
    l = ln_mag(r, neg);
    tb = q24_mul(q48_coef(b_man[set], 13), l);
    l3 = q24_mul(q24_mul(l, l), l);
    tc = q24_mul(q48_coef(c_man[set], c_pow[set]), l3);
    den = neg ? longint'(q48_coef(a_man[set], 12)) - longint'(tb + tc)
              : longint'(q48_coef(a_man[set], 12)) + longint'(tb + tc);
    if (den == 0) return 511;
    if (den > 0) kelvin = (64'sd1 <<< 48) / den;
    else kelvin = -((64'sd1 <<< 48) / (-den));
    return kelvin - 273;
  endfunction

  // fold one accepted sample into the averaging state, queue a reading if one is due
  task automatic predict_sample(input logic [11:0] s);
    longint unsigned avg, r;
    longint t;
    int found;
    reading_t rd;
    accum_sum = accum_sum + 18'(s);
    accum_count = accum_count + 1;
    if (accum_count < ttc_pkg::SAMPLES_PER_AVERAGE) return;
    avg = accum_sum / ttc_pkg::SAMPLES_PER_AVERAGE;
    accum_sum = '0;
    accum_count = '0;
    t = 0;
    found = -1;
    if (avg == 0) begin
      rd.status = ttc_pkg::ST_INVALID;
    end else begin
      r = (longint'(rref_ohms) * (4095 - avg) * 256) / avg;
      if (r > R_SAT) r = R_SAT;
      if (r >= band_floor[0] && r <= ttc_pkg::TOP_EDGE) begin
        for (int k = 0; k < 13; k++) if (r >= band_floor[k]) found = k;
      end
      if (found >= 0) begin
        held_set = 4'(found);
        rd.status = ttc_pkg::ST_FOUND;
      end else begin
        rd.status = (held_set != ttc_pkg::NO_BAND) ? ttc_pkg::ST_HELD : ttc_pkg::ST_INVALID;
      end
      if (rd.status != ttc_pkg::ST_INVALID) begin
        t = steinhart_celsius(r, held_set);
        if (t > 511) t = 511;
        if (t < -512) t = -512;
      end
    end
    rd.temp_c = 10'(t);
    pending_readings.push_back(rd);
  endtask

  // one sample request; may idle first, keeps tvalid high between back-to-back requests
  task automatic send_sample(input logic [11:0] s);
    if ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, s};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    predict_sample(s);
  endtask

  task automatic send_group(input int level);
    for (int i = 0; i < ttc_pkg::SAMPLES_PER_AVERAGE; i++) send_sample(12'(level));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // register write only while the converter is idle
  task automatic write_rref(input logic [19:0] ohms);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= {4'($urandom_range(15)), ohms};
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    rref_ohms = ohms;
  endtask

  // check each accepted reading against the oldest prediction
  always @(negedge clk) begin
    reading_t exp_rd;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected reading temperature_c=%0d status=%0d",
               $signed(out_tdata[9:0]), out_tuser[1:0]);
        errors++;
      end else begin
        exp_rd = pending_readings.pop_front();
        if (out_tdata[9:0] !== exp_rd.temp_c) begin
          $error("temperature_c expected %0d actual %0d", exp_rd.temp_c,
                 $signed(out_tdata[9:0]));
          errors++;
        end
        if (out_tuser[1:0] !== exp_rd.status) begin
          $error("status expected %0d actual %0d", exp_rd.status, out_tuser[1:0]);
          errors++;
        end
      end
    end
  end

  // extremes and the special cases at the reset resistor value
  task automatic test_special_cases();
    send_group(0);      // zero average: invalid
    send_group(4095);   // zero resistance before any band: invalid
    send_group(2048);   // mid scale: band found
    send_group(4095);   // zero resistance with a set held: zero kelvin
    for (int i = 0; i < ttc_pkg::SAMPLES_PER_AVERAGE; i++)
      send_sample((i % 2) ? 12'hfff : 12'h000);
  endtask

  // random averaging groups, mostly aimed at resistances inside the bands
  task automatic test_random_phase(input int groups, input logic [19:0] ohms,
                                   input int idle_mode, input bit hold_off);
    int target, sel, v;
    real ohm_goal;
    write_rref(ohms);
    in_idle_pct = (idle_mode == 0) ? 36 : (idle_mode == 1) ? 63 : 0;
    out_idle_pct = (idle_mode == 0) ? 63 : (idle_mode == 1) ? 36 : 0;
    for (int g = 0; g < groups; g++) begin
      if (hold_off && g == groups / 2) wait_drained();
      sel = $urandom_range(99);
      if (sel < 6) target = 0;
      else if (sel < 12) target = 4095;
      else if (sel < 30) target = $urandom_range(4095);
      else begin
        ohm_goal = 20.0 * (2.0 ** ($urandom_range(1100) / 100.0));
        target = int'(4095.0 * rref_ohms / (rref_ohms + ohm_goal));
      end
      for (int i = 0; i < ttc_pkg::SAMPLES_PER_AVERAGE; i++) begin
        if (sel >= 90) v = $urandom_range(4095);
        else v = target + $urandom_range(6) - 3;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        send_sample(12'(v));
      end
    end
  endtask

  initial begin
    rref_ohms = ttc_pkg::RREF_RESET;
    accum_sum = '0;
    accum_count = '0;
    held_set = ttc_pkg::NO_BAND;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_cases();
    test_random_phase(15, 20'd1, 0, 1'b0);
    test_random_phase(15, 20'd1000000, 1, 1'b1);
    test_random_phase(15, 20'hfffff, 2, 1'b0);
    test_random_phase(10, 20'($urandom_range(1048575, 1)), 0, 1'b0);
    test_random_phase(10, 20'd9870, 2, 1'b0);

    wait_drained();
    repeat (1300) @(posedge clk);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
